[rtl/assert_macros.svh]
// Assertion helpers for the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clk_i edge outside reset
`define ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT(lbl, !(cond), msg)

`else

`define ASSERT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/tss_pkg.sv]
`default_nettype none

package tss_pkg;

  // Width of the byte position counter
  localparam int unsigned POS_BITS = 16;
  // Fixed width of the start and length result fields
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned KW_COUNT = 12;
  localparam int unsigned SLOT_COUNT = 3;

  // Result status codes
  localparam logic [1:0] ST_TOKEN = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  // Token kinds that are not keywords
  localparam logic [5:0] KIND_QUEST  = 6'd5;
  localparam logic [5:0] KIND_COLON  = 6'd6;
  localparam logic [5:0] KIND_TILDE  = 6'd12;
  localparam logic [5:0] KIND_DEC    = 6'd13;
  localparam logic [5:0] KIND_NOT    = 6'd14;
  localparam logic [5:0] KIND_MINUS  = 6'd15;
  localparam logic [5:0] KIND_PLUS   = 6'd16;
  localparam logic [5:0] KIND_STAR   = 6'd17;
  localparam logic [5:0] KIND_SLASH  = 6'd18;
  localparam logic [5:0] KIND_PCT    = 6'd19;
  localparam logic [5:0] KIND_LAND   = 6'd20;
  localparam logic [5:0] KIND_LOR    = 6'd21;
  localparam logic [5:0] KIND_ASSIGN = 6'd22;
  localparam logic [5:0] KIND_EQ     = 6'd23;
  localparam logic [5:0] KIND_NE     = 6'd24;
  localparam logic [5:0] KIND_LT     = 6'd25;
  localparam logic [5:0] KIND_GT     = 6'd26;
  localparam logic [5:0] KIND_LE     = 6'd27;
  localparam logic [5:0] KIND_GE     = 6'd28;
  localparam logic [5:0] KIND_IDENT  = 6'd29;
  localparam logic [5:0] KIND_CONST  = 6'd30;
  localparam logic [5:0] KIND_LPAREN = 6'd31;
  localparam logic [5:0] KIND_RPAREN = 6'd32;
  localparam logic [5:0] KIND_LBRACE = 6'd33;
  localparam logic [5:0] KIND_RBRACE = 6'd34;
  localparam logic [5:0] KIND_SEMI   = 6'd35;
  localparam logic [5:0] KIND_COMMA  = 6'd36;

  // Scanner mode: idle, a run in progress, or an operator awaiting its second byte
  typedef enum logic [9:0] {
    MODE_IDLE   = 10'b00_0000_0001,
    MODE_WORD   = 10'b00_0000_0010,
    MODE_NUM    = 10'b00_0000_0100,
    MODE_MINUS  = 10'b00_0000_1000,
    MODE_BANG   = 10'b00_0001_0000,
    MODE_ASSIGN = 10'b00_0010_0000,
    MODE_LT     = 10'b00_0100_0000,
    MODE_GT     = 10'b00_1000_0000,
    MODE_AMP    = 10'b01_0000_0000,
    MODE_BAR    = 10'b10_0000_0000
  } mode_e;

  // One result beat
  typedef struct packed {
    logic [1:0]            status;
    logic [5:0]            kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } res_t;

  // Results of one byte, handed from the scanner core to the result buffer
  typedef struct packed {
    logic                  load;
    logic [1:0]            count;
    res_t [SLOT_COUNT-1:0] slot;
  } grp_t;

  // Low bits of a position, zero extended when the counter is narrow
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/tss_if.sv]
`default_nettype none

// Source byte channel
interface tss_in_if;
  import tss_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source(output valid, char_byte, final_byte, input ready);
  modport sink(input valid, char_byte, final_byte, output ready);
endinterface

// Result channel
interface tss_out_if;
  import tss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            result_status;
  logic [5:0]            token_kind;
  logic [FIELD_BITS-1:0] token_start;
  logic [FIELD_BITS-1:0] token_length;
  logic                  step_last;

  modport source(output valid, result_status, token_kind, token_start, token_length,
                 step_last, input ready);
  modport sink(input valid, result_status, token_kind, token_start, token_length,
               step_last, output ready);
endinterface

`default_nettype wire

[rtl/tss_in_reg.sv]
`default_nettype none

module tss_in_reg (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tss_in_if.sink     in_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       fin_o
);
  import tss_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       fin_q;
  logic       load;

  // Take a new beat when empty or when the held one moves on
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload of the waiting byte
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= in_i.char_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign fin_o   = fin_q;

endmodule

`default_nettype wire

[rtl/tss_core.sv]
`default_nettype none

module tss_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          fin_i,
  input  wire logic          free_i,
  output logic               take_o,
  output tss_pkg::grp_t      grp_o
);
  import tss_pkg::*;

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd6, 4'd2, 4'd4, 4'd0, 4'd0, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8
  };

  typedef struct packed {
    logic valid;
    logic err;
    res_t res;
  } cand_t;

  typedef struct packed {
    mode_e               mode;
    logic                set_pend;
    logic [KW_COUNT-1:0] mask;
    cand_t               out;
  } beg_t;

  // Keyword text, one byte per index
  function automatic logic [7:0] kw_char(input int b, input logic [2:0] i);
    logic [63:0] w;
    case (b)
      0:       w = {"int", 40'h0};
      1:       w = {"void", 32'h0};
      2:       w = {"return", 16'h0};
      3:       w = {"if", 48'h0};
      4:       w = {"else", 32'h0};
      7:       w = {"do", 48'h0};
      8:       w = {"while", 24'h0};
      9:       w = {"for", 40'h0};
      10:      w = {"break", 24'h0};
      11:      w = "continue";
      default: w = '0;
    endcase
    return w[8*(7 - int'(i)) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
  endfunction

  // Keep the keywords that still match at this index
  function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] mask,
                                                 input logic [POS_BITS-1:0] idx,
                                                 input logic [7:0] c);
    logic [KW_COUNT-1:0] keep;
    keep = '0;
    for (int b = 0; b < KW_COUNT; b++) begin
      keep[b] = mask[b] && (idx < POS_BITS'(KW_LEN[b])) && (kw_char(b, idx[2:0]) == c);
    end
    return keep;
  endfunction

  // Lowest live keyword of full length, else identifier
  function automatic logic [5:0] kw_kind(input logic [KW_COUNT-1:0] mask,
                                         input logic [POS_BITS-1:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int b = KW_COUNT - 1; b >= 0; b--) begin
      if (mask[b] && (len == POS_BITS'(KW_LEN[b]))) begin
        kind = 6'(b);
      end
    end
    return kind;
  endfunction

  function automatic cand_t mk_tok(input logic [5:0] kind,
                                   input logic [FIELD_BITS-1:0] start,
                                   input logic [FIELD_BITS-1:0] len);
    cand_t r;
    r.valid      = 1'b1;
    r.err        = 1'b0;
    r.res.status = ST_TOKEN;
    r.res.kind   = kind;
    r.res.start  = start;
    r.res.length = len;
    r.res.last   = 1'b0;
    return r;
  endfunction

  function automatic cand_t mk_err(input logic [FIELD_BITS-1:0] start);
    cand_t r;
    r            = mk_tok('0, start, '0);
    r.err        = 1'b1;
    r.res.status = ST_ERROR;
    return r;
  endfunction

  // Token emitted when the pending run or operator ends
  function automatic cand_t flush_of(input mode_e mode,
                                     input logic [KW_COUNT-1:0] mask,
                                     input logic [POS_BITS-1:0] plen,
                                     input logic [POS_BITS-1:0] pstart);
    cand_t r;
    logic [FIELD_BITS-1:0] s;
    logic [FIELD_BITS-1:0] one;
    s   = to_field(pstart);
    one = FIELD_BITS'(1);
    r   = '0;
    case (mode)
      MODE_WORD:   r = mk_tok(kw_kind(mask, plen), s, to_field(plen));
      MODE_NUM:    r = mk_tok(KIND_CONST, s, to_field(plen));
      MODE_MINUS:  r = mk_tok(KIND_MINUS, s, one);
      MODE_BANG:   r = mk_tok(KIND_NOT, s, one);
      MODE_ASSIGN: r = mk_tok(KIND_ASSIGN, s, one);
      MODE_LT:     r = mk_tok(KIND_LT, s, one);
      MODE_GT:     r = mk_tok(KIND_GT, s, one);
      MODE_AMP:    r = mk_err(s);
      MODE_BAR:    r = mk_err(s);
      default:     r = '0;
    endcase
    return r;
  endfunction

  // Start of a new token at this byte
  function automatic beg_t begin_of(input logic [7:0] c, input logic [POS_BITS-1:0] pos);
    beg_t r;
    logic [FIELD_BITS-1:0] s;
    logic [FIELD_BITS-1:0] one;
    s          = to_field(pos);
    one        = FIELD_BITS'(1);
    r.mode     = MODE_IDLE;
    r.set_pend = 1'b0;
    r.mask     = '1;
    r.out      = '0;
    if (c == " " || c inside {[8'h09:8'h0d]}) begin
      r.mode = MODE_IDLE;
    end else if (is_word(c) && !is_digit(c)) begin
      r.mode     = MODE_WORD;
      r.set_pend = 1'b1;
      r.mask     = narrow('1, '0, c);
    end else if (is_digit(c)) begin
      r.mode     = MODE_NUM;
      r.set_pend = 1'b1;
    end else begin
      r.set_pend = 1'b1;
      case (c)
        "-":     r.mode = MODE_MINUS;
        "!":     r.mode = MODE_BANG;
        "=":     r.mode = MODE_ASSIGN;
        "<":     r.mode = MODE_LT;
        ">":     r.mode = MODE_GT;
        "&":     r.mode = MODE_AMP;
        "|":     r.mode = MODE_BAR;
        default: r.set_pend = 1'b0;
      endcase
      if (!r.set_pend) begin
        case (c)
          "?":     r.out = mk_tok(KIND_QUEST, s, one);
          ":":     r.out = mk_tok(KIND_COLON, s, one);
          "~":     r.out = mk_tok(KIND_TILDE, s, one);
          "+":     r.out = mk_tok(KIND_PLUS, s, one);
          "*":     r.out = mk_tok(KIND_STAR, s, one);
          "/":     r.out = mk_tok(KIND_SLASH, s, one);
          "%":     r.out = mk_tok(KIND_PCT, s, one);
          "(":     r.out = mk_tok(KIND_LPAREN, s, one);
          ")":     r.out = mk_tok(KIND_RPAREN, s, one);
          "{":     r.out = mk_tok(KIND_LBRACE, s, one);
          "}":     r.out = mk_tok(KIND_RBRACE, s, one);
          ";":     r.out = mk_tok(KIND_SEMI, s, one);
          ",":     r.out = mk_tok(KIND_COMMA, s, one);
          default: r.out = mk_err(s);
        endcase
      end
    end
    return r;
  endfunction

  mode_e               mode_q, mode_d, mode1;
  logic [POS_BITS-1:0] cnt_q, cnt_d;
  logic [POS_BITS-1:0] pstart_q, pstart_d, pstart1;
  logic [POS_BITS-1:0] plen_q, plen_d, plen1;
  logic [KW_COUNT-1:0] mask_q, mask_d, mask1;
  logic                disc_q, disc_d, disc1;

  logic                pos_max;
  logic [POS_BITS-1:0] pos_next;
  cand_t               fc, ca, cb, cc, cd, fin_fl;
  beg_t                bg;
  logic                use_flush, use_begin;
  logic [7:0]          pair_c;
  logic [5:0]          two_k;
  logic                lone_bad;
  cand_t               cand [4];
  logic [2:0]          n;
  res_t [SLOT_COUNT-1:0] slot;

  assign take_o   = valid_i && free_i;
  assign pos_max  = &cnt_q;
  assign pos_next = pos_max ? cnt_q : cnt_q + POS_BITS'(1);

  // Second byte and kind of each two-byte operator
  always_comb begin
    pair_c   = "=";
    two_k    = KIND_EQ;
    lone_bad = 1'b0;
    case (mode_q)
      MODE_MINUS:  begin pair_c = "-"; two_k = KIND_DEC; end
      MODE_BANG:   begin pair_c = "="; two_k = KIND_NE; end
      MODE_ASSIGN: begin pair_c = "="; two_k = KIND_EQ; end
      MODE_LT:     begin pair_c = "="; two_k = KIND_LE; end
      MODE_GT:     begin pair_c = "="; two_k = KIND_GE; end
      MODE_AMP:    begin pair_c = "&"; two_k = KIND_LAND; lone_bad = 1'b1; end
      MODE_BAR:    begin pair_c = "|"; two_k = KIND_LOR; lone_bad = 1'b1; end
      default:     lone_bad = 1'b0;
    endcase
  end

  // Advance the scanner by one byte
  always_comb begin
    fc        = flush_of(mode_q, mask_q, plen_q, pstart_q);
    bg        = begin_of(char_i, cnt_q);
    mode1     = mode_q;
    pstart1   = pstart_q;
    plen1     = plen_q;
    mask1     = mask_q;
    disc1     = disc_q;
    ca        = '0;
    cb        = '0;
    use_flush = 1'b0;
    use_begin = 1'b0;

    if (disc_q) begin
      disc1 = 1'b1;
    end else if (pos_max) begin
      ca    = mk_err(to_field(cnt_q));
      disc1 = 1'b1;
      mode1 = MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_IDLE: use_begin = 1'b1;
        MODE_WORD: begin
          if (is_word(char_i)) begin
            mask1 = narrow(mask_q, plen_q, char_i);
            plen1 = plen_q + POS_BITS'(1);
          end else begin
            use_flush = 1'b1;
            use_begin = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(char_i)) begin
            plen1 = plen_q + POS_BITS'(1);
          end else if (is_word(char_i)) begin
            ca    = mk_err(to_field(pstart_q));
            disc1 = 1'b1;
            mode1 = MODE_IDLE;
          end else begin
            use_flush = 1'b1;
            use_begin = 1'b1;
          end
        end
        MODE_MINUS, MODE_BANG, MODE_ASSIGN, MODE_LT, MODE_GT, MODE_AMP, MODE_BAR: begin
          if (char_i == pair_c) begin
            ca    = mk_tok(two_k, to_field(pstart_q), FIELD_BITS'(2));
            mode1 = MODE_IDLE;
          end else if (lone_bad) begin
            ca    = mk_err(to_field(pstart_q));
            disc1 = 1'b1;
            mode1 = MODE_IDLE;
          end else begin
            use_flush = 1'b1;
            use_begin = 1'b1;
          end
        end
        default: mode1 = MODE_IDLE;
      endcase
    end

    // Close the pending token, then open the next one
    if (use_flush) begin
      ca    = fc;
      mode1 = MODE_IDLE;
      mask1 = '1;
    end
    if (use_begin) begin
      cb    = bg.out;
      mode1 = bg.mode;
      if (bg.set_pend) begin
        pstart1 = cnt_q;
        plen1   = POS_BITS'(1);
      end
      if (bg.mode == MODE_WORD) begin
        mask1 = bg.mask;
      end
      if (bg.out.err) begin
        disc1 = 1'b1;
      end
    end

    // Last byte: flush what is left and report the end
    fin_fl = flush_of(mode1, mask1, plen1, pstart1);
    cc     = '0;
    cd     = '0;
    if (fin_i) begin
      if (!disc1) begin
        cc = fin_fl;
      end
      cd            = mk_tok('0, to_field(pos_next), '0);
      cd.res.status = ST_END;
    end

    if (fin_i) begin
      mode_d   = MODE_IDLE;
      cnt_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
      mask_d   = '1;
      disc_d   = 1'b0;
    end else begin
      mode_d   = mode1;
      cnt_d    = pos_next;
      pstart_d = pstart1;
      plen_d   = plen1;
      mask_d   = mask1;
      disc_d   = disc1;
    end
  end

  // Pack the results of this byte into consecutive slots
  always_comb begin
    cand[0] = ca;
    cand[1] = cb;
    cand[2] = cc;
    cand[3] = cd;
    slot    = '0;
    n       = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand[k].valid && (n < 3'(SLOT_COUNT))) begin
        slot[n[1:0]] = cand[k].res;
        n            = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      slot[n[1:0] - 2'd1].last = 1'b1;
    end
  end

  assign grp_o.load  = take_o;
  assign grp_o.count = n[1:0];
  assign grp_o.slot  = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      cnt_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      mask_q   <= '1;
      disc_q   <= 1'b0;
    end else if (take_o) begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      mask_q   <= mask_d;
      disc_q   <= disc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tss_res_buf.sv]
`default_nettype none

`include "assert_macros.svh"

module tss_res_buf (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  tss_pkg::grp_t  grp_i,
  output logic           free_o,
  tss_out_if.source      out_o
);
  import tss_pkg::*;

  logic [1:0]            cnt_q, cnt_d;
  res_t [SLOT_COUNT-1:0] slot_q, slot_d;
  logic                  pop;

  assign pop    = (cnt_q != 2'd0) && out_o.ready;
  // Room for a new group once the last waiting beat leaves
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  // Load a new group or shift toward the output slot
  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (grp_i.load) begin
      cnt_d  = grp_i.count;
      slot_d = grp_i.slot;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.result_status = slot_q[0].status;
  assign out_o.token_kind    = slot_q[0].kind;
  assign out_o.token_start   = slot_q[0].start;
  assign out_o.token_length  = slot_q[0].length;
  assign out_o.step_last     = slot_q[0].last;

  `ASSERT(a_load_when_free, grp_i.load |-> free_o, "group loaded over waiting results")
  `ASSERT(a_single_is_last, (cnt_q == 2'd1) |-> slot_q[0].last, "lone beat not marked last")
  `ASSERT_NEVER(a_early_last, (cnt_q > 2'd1) && slot_q[0].last, "last flag ahead of group end")
  `ASSERT(a_pop_count, (pop && !grp_i.load) |=> (cnt_q == $past(cnt_q) - 2'd1),
          "count did not follow a taken beat")

endmodule

`default_nettype wire

[rtl/c_subset_token_scanner.sv]
// Token scanner for a small C subset, longest match, keywords before identifiers.
// in_i carries one source byte per beat with final_byte set on the last byte of a
// source; out_o carries result beats (token, lexical error, or end of input) with
// step_last set on the last beat that a byte causes. A byte causes zero to three
// beats; the end beat follows the final byte and the scanner then restarts at
// position zero.
// An accepted byte waits in the input register while the core scans it; its result
// beats are registered in the result buffer and then appear on out_o.
// Throughput: one byte per cycle while each byte yields at most one beat and out_o
// is ready; a byte with more beats holds the input until its beats leave, as the result
// port moves one beat per cycle and the three-slot result buffer takes a new byte
// only once its last waiting beat leaves. When out_o stalls, the result buffer holds
// its beats and one more byte waits in the input register; in_i.ready then drops.
// Reset clears the scan state, position counter and both buffers at once; no
// clearing pass is needed.
`default_nettype none

module c_subset_token_scanner (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tss_in_if.sink    in_i,
  tss_out_if.source out_o
);
  import tss_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_fin;
  logic       take;
  logic       free;
  grp_t       grp;

  tss_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .char_o  (in_char),
    .fin_o   (in_fin)
  );

  tss_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .char_i  (in_char),
    .fin_i   (in_fin),
    .free_i  (free),
    .take_o  (take),
    .grp_o   (grp)
  );

  tss_res_buf u_res_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grp_i  (grp),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned RANDOM_BYTES = 290;
  localparam logic [POS_BITS-1:0] POS_TOP = '1;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;
  // Kind field carried by error and end beats
  localparam logic [5:0] KIND_NONE = 6'd0;

  logic clk_i;
  logic rst_ni;

  tss_in_if  in_bus ();
  tss_out_if out_bus ();

  c_subset_token_scanner dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Scanner state mirrored by the token predictor
  mode_e                 scan_md;
  logic [POS_BITS-1:0]   byte_pos;
  logic [POS_BITS-1:0]   tok_start;
  logic [FIELD_BITS-1:0] tok_len;
  logic [KW_COUNT-1:0]   kw_live;
  bit                    skipping;

  res_t        expected_beats[$];
  logic [7:0]  src_bytes[$];

  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned token_beats;
  int unsigned error_beats;
  int unsigned end_beats;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run in case a handshake hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("c_subset_token_scanner test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic string keyword_text(int unsigned b);
    case (b)
      0:  return "int";
      1:  return "void";
      2:  return "return";
      3:  return "if";
      4:  return "else";
      7:  return "do";
      8:  return "while";
      9:  return "for";
      10: return "break";
      11: return "continue";
      default: return "";
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_op_mode(mode_e m);
    return !(m inside {MODE_IDLE, MODE_WORD, MODE_NUM});
  endfunction

  // & and | have no one-byte token of their own
  function automatic bit op_lone_ok(mode_e m);
    return !(m inside {MODE_AMP, MODE_BAR});
  endfunction

  function automatic logic [7:0] op_second(mode_e m);
    case (m)
      MODE_MINUS: return "-";
      MODE_AMP:   return "&";
      MODE_BAR:   return "|";
      default:    return "=";
    endcase
  endfunction

  function automatic logic [5:0] op_single(mode_e m);
    case (m)
      MODE_MINUS:  return KIND_MINUS;
      MODE_BANG:   return KIND_NOT;
      MODE_ASSIGN: return KIND_ASSIGN;
      MODE_LT:     return KIND_LT;
      default:     return KIND_GT;
    endcase
  endfunction

  function automatic logic [5:0] op_double(mode_e m);
    case (m)
      MODE_MINUS:  return KIND_DEC;
      MODE_BANG:   return KIND_NE;
      MODE_ASSIGN: return KIND_EQ;
      MODE_LT:     return KIND_LE;
      MODE_GT:     return KIND_GE;
      MODE_AMP:    return KIND_LAND;
      default:     return KIND_LOR;
    endcase
  endfunction

  // Keep the keywords whose byte at idx matches c
  function automatic logic [KW_COUNT-1:0] narrow_keywords(logic [KW_COUNT-1:0] live,
                                                          int unsigned idx, logic [7:0] c);
    logic [KW_COUNT-1:0] keep;
    string w;
    keep = '0;
    for (int b = 0; b < KW_COUNT; b++) begin
      w = keyword_text(b);
      if (live[b] && idx < w.len() && w[idx] == c) keep[b] = 1'b1;
    end
    return keep;
  endfunction

  function automatic void clear_scanner();
    scan_md   = MODE_IDLE;
    byte_pos  = '0;
    tok_start = '0;
    tok_len   = '0;
    kw_live   = KW_ALL;
    skipping  = 1'b0;
  endfunction

  function automatic void push_beat(logic [1:0] st, logic [5:0] kind,
                                    logic [POS_BITS-1:0] start, logic [FIELD_BITS-1:0] len);
    res_t r;
    r.status = st;
    r.kind   = kind;
    r.start  = start;
    r.length = len;
    r.last   = 1'b0;
    expected_beats.push_back(r);
  endfunction

  function automatic void mark_error(logic [POS_BITS-1:0] start);
    push_beat(ST_ERROR, KIND_NONE, start, '0);
    skipping = 1'b1;
    scan_md  = MODE_IDLE;
  endfunction

  // Emit the pending token, if any; a lone & or | turns into an error
  function automatic void flush_pending();
    logic [5:0] kind;
    string w;
    if (scan_md == MODE_WORD) begin
      kind = KIND_IDENT;
      // walk downward so the lowest matching keyword index wins
      for (int b = KW_COUNT - 1; b >= 0; b--) begin
        w = keyword_text(b);
        if (kw_live[b] && w.len() == tok_len) kind = 6'(b);
      end
      push_beat(ST_TOKEN, kind, tok_start, tok_len);
    end else if (scan_md == MODE_NUM) begin
      push_beat(ST_TOKEN, KIND_CONST, tok_start, tok_len);
    end else if (is_op_mode(scan_md)) begin
      if (!op_lone_ok(scan_md)) begin
        mark_error(tok_start);
        return;
      end
      push_beat(ST_TOKEN, op_single(scan_md), tok_start, 16'd1);
    end
    scan_md = MODE_IDLE;
    kw_live = KW_ALL;
  endfunction

  // Open a new token on byte c at position pos
  function automatic void start_token(logic [7:0] c, logic [POS_BITS-1:0] pos);
    scan_md = MODE_IDLE;
    if (is_space(c)) return;
    if (is_word_char(c) && !is_digit(c)) begin
      scan_md   = MODE_WORD;
      tok_start = pos;
      tok_len   = 16'd1;
      kw_live   = narrow_keywords(KW_ALL, 0, c);
      return;
    end
    if (is_digit(c)) begin
      scan_md   = MODE_NUM;
      tok_start = pos;
      tok_len   = 16'd1;
      return;
    end
    case (c)
      "-": scan_md = MODE_MINUS;
      "!": scan_md = MODE_BANG;
      "=": scan_md = MODE_ASSIGN;
      "<": scan_md = MODE_LT;
      ">": scan_md = MODE_GT;
      "&": scan_md = MODE_AMP;
      "|": scan_md = MODE_BAR;
      "?": push_beat(ST_TOKEN, KIND_QUEST, pos, 16'd1);
      ":": push_beat(ST_TOKEN, KIND_COLON, pos, 16'd1);
      "~": push_beat(ST_TOKEN, KIND_TILDE, pos, 16'd1);
      "+": push_beat(ST_TOKEN, KIND_PLUS, pos, 16'd1);
      "*": push_beat(ST_TOKEN, KIND_STAR, pos, 16'd1);
      "/": push_beat(ST_TOKEN, KIND_SLASH, pos, 16'd1);
      "%": push_beat(ST_TOKEN, KIND_PCT, pos, 16'd1);
      "(": push_beat(ST_TOKEN, KIND_LPAREN, pos, 16'd1);
      ")": push_beat(ST_TOKEN, KIND_RPAREN, pos, 16'd1);
      "{": push_beat(ST_TOKEN, KIND_LBRACE, pos, 16'd1);
      "}": push_beat(ST_TOKEN, KIND_RBRACE, pos, 16'd1);
      ";": push_beat(ST_TOKEN, KIND_SEMI, pos, 16'd1);
      ",": push_beat(ST_TOKEN, KIND_COMMA, pos, 16'd1);
      default: mark_error(pos);
    endcase
    if (is_op_mode(scan_md)) begin
      tok_start = pos;
      tok_len   = 16'd1;
    end
  endfunction

  // Work out the beats caused by one accepted source byte
  function automatic void predict_byte(logic [7:0] c, bit fin);
    logic [POS_BITS-1:0] pos;
    int unsigned before_cnt;
    res_t r;
    pos = byte_pos;
    before_cnt = expected_beats.size();
    if (!skipping) begin
      if (pos == POS_TOP) begin
        mark_error(POS_TOP);
      end else if (scan_md == MODE_WORD) begin
        if (is_word_char(c)) begin
          kw_live = narrow_keywords(kw_live, tok_len, c);
          tok_len = tok_len + 1'b1;
        end else begin
          flush_pending();
          start_token(c, pos);
        end
      end else if (scan_md == MODE_NUM) begin
        if (is_digit(c)) begin
          tok_len = tok_len + 1'b1;
        end else if (is_word_char(c)) begin
          mark_error(tok_start);
        end else begin
          flush_pending();
          start_token(c, pos);
        end
      end else if (is_op_mode(scan_md)) begin
        if (c == op_second(scan_md)) begin
          push_beat(ST_TOKEN, op_double(scan_md), tok_start, 16'd2);
          scan_md = MODE_IDLE;
        end else if (!op_lone_ok(scan_md)) begin
          mark_error(tok_start);
        end else begin
          flush_pending();
          start_token(c, pos);
        end
      end else begin
        start_token(c, pos);
      end
    end
    if (fin) begin
      if (!skipping) flush_pending();
      push_beat(ST_END, KIND_NONE, (pos < POS_TOP) ? pos + 1'b1 : POS_TOP, '0);
      clear_scanner();
    end else begin
      byte_pos = (pos < POS_TOP) ? pos + 1'b1 : POS_TOP;
    end
    // flag the last beat of this byte
    if (expected_beats.size() > before_cnt) begin
      r = expected_beats.pop_back();
      r.last = 1'b1;
      expected_beats.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------

  task automatic send_byte(logic [7:0] c, bit fin);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.char_byte  <= c;
    in_bus.final_byte <= fin;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_byte(c, fin);
    bytes_sent++;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endfunction

  // Send the collected source, marking its last byte as final
  task automatic send_source();
    for (int i = 0; i < src_bytes.size(); i++) send_byte(src_bytes[i], i == src_bytes.size() - 1);
    src_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    mismatch_count++;
  endtask

  task automatic check_result();
    res_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got status %0d kind %0d start %0d len %0d",
               $time, out_bus.result_status, out_bus.token_kind, out_bus.token_start,
               out_bus.token_length);
      mismatch_count++;
      return;
    end
    want = expected_beats.pop_front();
    case (want.status)
      ST_TOKEN: token_beats++;
      ST_ERROR: error_beats++;
      default:  end_beats++;
    endcase
    if (out_bus.result_status !== want.status)
      report_field("result_status", 32'(want.status), 32'(out_bus.result_status));
    if (out_bus.token_kind !== want.kind)
      report_field("token_kind", 32'(want.kind), 32'(out_bus.token_kind));
    if (out_bus.token_start !== want.start)
      report_field("token_start", 32'(want.start), 32'(out_bus.token_start));
    if (out_bus.token_length !== want.length)
      report_field("token_length", 32'(want.length), 32'(out_bus.token_length));
    if (out_bus.step_last !== want.last)
      report_field("step_last", 32'(want.last), 32'(out_bus.step_last));
  endtask

  initial begin : result_checker
    int unsigned stall;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      // take a requested long hold-off, else a short random stall
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_keyword();
    int unsigned b;
    b = $urandom_range(0, 9);
    // skip the two empty table slots
    return (b >= 5) ? b + 2 : b;
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range("a", "z"));
      1:       return 8'($urandom_range("A", "Z"));
      2:       return 8'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return " ";
    endcase
  endfunction

  function automatic string op_text(int unsigned i);
    case (i)
      0:  return "--";
      1:  return "&&";
      2:  return "||";
      3:  return "==";
      4:  return "!=";
      5:  return "<=";
      6:  return ">=";
      7:  return "-";
      8:  return "!";
      9:  return "=";
      10: return "<";
      11: return ">";
      12: return "?";
      13: return ":";
      14: return "~";
      15: return "+";
      16: return "*";
      17: return "/";
      18: return "%";
      19: return "(";
      20: return ")";
      21: return "{";
      22: return "}";
      23: return ";";
      24: return ",";
      25: return "&";
      default: return "|";
    endcase
  endfunction

  function automatic void add_random_lexeme();
    string w;
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1: add_text(keyword_text(pick_keyword()));
      2: begin
        // keyword cut short by one byte
        w = keyword_text(pick_keyword());
        add_text(w.substr(0, w.len() - 2));
      end
      3: begin
        // keyword run on by one word byte
        add_text(keyword_text(pick_keyword()));
        src_bytes.push_back(pick_word_char());
      end
      4, 5: begin
        n = $urandom_range(1, 6);
        src_bytes.push_back(($urandom_range(0, 4) == 0) ? "_" : 8'($urandom_range("a", "z")));
        repeat (n - 1) src_bytes.push_back(pick_word_char());
      end
      6: repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range("0", "9")));
      7, 8: add_text(op_text($urandom_range(0, 26)));
      default: src_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic test_directed_cases();
    // digit run followed by a word byte
    add_text("9x");
    send_source();
    // word flushed, then a lone ampersand at the end: three beats on one byte
    add_text("x&");
    send_source();
    // lone bar, then the rest of the source is dropped
    add_text("|a");
    send_source();
    // bytes outside the character set
    src_bytes.push_back(8'hFF);
    add_text(";");
    send_source();
    src_bytes.push_back(8'h00);
    send_source();
    // two-byte operators back to back
    add_text("<=>=");
    send_source();
    // keyword closed by a punctuator on the final byte
    add_text("if(");
    send_source();
    // number closed by whitespace, whitespace as final byte
    src_bytes.push_back(" ");
    add_text("7");
    src_bytes.push_back(8'h09);
    send_source();
    // decrement, then a pending bang flushed by the final byte
    add_text("--!");
    send_source();
  endtask

  task automatic test_back_pressure();
    // stall the result side while the sender keeps offering bytes
    hold_cycles = 60;
    repeat (20) add_text("a;");
    send_source();
  endtask

  task automatic test_random_sources();
    int unsigned start_cnt;
    int unsigned n_lex;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < RANDOM_BYTES) begin
      n_lex = $urandom_range(1, 8);
      repeat (n_lex) begin
        add_random_lexeme();
        // mostly keep lexemes apart, sometimes let them touch
        if ($urandom_range(0, 4) != 0) src_bytes.push_back(pick_space());
      end
      send_source();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.char_byte  <= '0;
    in_bus.final_byte <= 1'b0;
    hold_cycles    = 0;
    mismatch_count = 0;
    bytes_sent     = 0;
    token_beats    = 0;
    error_beats    = 0;
    end_beats      = 0;
    clear_scanner();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_back_pressure();
    test_random_sources();
    in_bus.valid <= 1'b0;

    // drain, then watch for stray beats
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
      mismatch_count++;
    end

    $display("Scanned %0d source bytes into %0d tokens, %0d lexical errors and %0d end beats,",
             bytes_sent, token_beats, error_beats, end_beats);
    $display("covering corner cases, random sources and a long stall on the result side.");
    if (mismatch_count == 0) begin
      $display("c_subset_token_scanner test passed");
    end else begin
      $display("c_subset_token_scanner test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_in_reg.sv
rtl/tss_core.sv
rtl/tss_res_buf.sv
rtl/c_subset_token_scanner.sv
verif/tb_top.sv
